>>> rtl/rtp_pkg.sv
// Shared constants for the 2D rotate-and-translate block.
// Used by rtp_trig, rtp_front and the top level; no dependencies.
package rtp_pkg;

  // Angle register: 16-bit fraction of a full turn, top two bits are the quadrant
  localparam int ANGLE_W  = 16;
  localparam int QUAD_LSB = 14;
  localparam int RES_W    = 14;

  // Residue at exactly one eighth of a turn, and a full quarter turn
  localparam logic [RES_W:0] RES_EIGHTH  = 15'd8192;
  localparam logic [RES_W:0] RES_QUARTER = 15'd16384;

  // Series evaluation runs in unsigned Q30
  localparam int          Q30_W    = 30;
  localparam logic [30:0] Q30_ONE  = 31'h4000_0000;
  // pi/32768 scaled by 2^45: x = t * PI_SCALE >> 15 gives the angle in Q30
  localparam logic [31:0] PI_SCALE = 32'd3373259426;

  // Taylor divisors: sine terms first, then cosine terms
  localparam int          N_DIV      = 9;
  localparam int          DIV_IDX_W  = 4;
  localparam int          DIVISOR_W  = 7;
  localparam logic [DIVISOR_W-1:0] SERIES_DIV [N_DIV] = '{
    7'd72, 7'd42, 7'd20, 7'd6, 7'd90, 7'd56, 7'd30, 7'd12, 7'd2
  };
  localparam logic [DIV_IDX_W-1:0] SINE_LAST = 4'd3;
  localparam logic [DIV_IDX_W-1:0] COS_FIRST = 4'd4;
  localparam logic [DIV_IDX_W-1:0] COS_LAST  = 4'd8;

  // Reciprocals of the divisors: n / d == (n * RECIP) >> SHIFT exactly for n < 2^30
  localparam int RECIP_W = 32;
  localparam int SHIFT_W = 6;
  localparam logic [RECIP_W-1:0] SERIES_RECIP [N_DIV] = '{
    32'd1908874354, 32'd1636178018, 32'd1717986919, 32'd1431655766,
    32'd1527099484, 32'd1227133514, 32'd1145324613, 32'd1431655766,
    32'd1073741824
  };
  localparam logic [SHIFT_W-1:0] SERIES_SHIFT [N_DIV] = '{
    6'd37, 6'd36, 6'd35, 6'd33, 6'd37, 6'd36, 6'd35, 6'd34, 6'd31
  };

  // Point queue between the front and back parts
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_ANGLE    = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_X = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y = 2'd2;

endpackage

>>> rtl/rotate_translate_point_2d.sv
// Rotate-then-translate of 2D fixed-point points, top level.
// Throughput 1 item per cycle while m_tready keeps up and no angle update is running.
// The datapath is a four-stage multiply/add pipeline fed from a 4-entry queue.
// After an angle write, s_tready is low while the trig unit runs.
// Reset (rst, synchronous): registers zero, cached sine 0, cached cosine 1.0,
// pipeline and queue empty. Uses rtp_pkg, rtp_trig, rtp_front, rtp_back.
module rotate_translate_point_2d #(
  parameter int  COORD_WIDTH = 32,
  parameter int  TRIG_WIDTH  = 16,
  localparam int APB_W       = (COORD_WIDTH > 32) ? 64 : 32,
  localparam int PADDR_W     = (COORD_WIDTH > 32) ? 5 : 4,
  localparam int IN_TW       = ((2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic               clk,
  input  logic               rst,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready,
  // Input points
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [IN_TW-1:0]   s_tdata,   // in_x, in_y
  // Results
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [IN_TW-1:0]   m_tdata,   // out_x, out_y
  output logic [0:0]         m_tuser    // saturated
);
  import rtp_pkg::*;

  localparam int REG_SHIFT = (COORD_WIDTH > 32) ? 3 : 2;

  logic [ANGLE_W-1:0]            angle_turns;
  logic [COORD_WIDTH-1:0]        offset_x;
  logic [COORD_WIDTH-1:0]        offset_y;
  logic [REG_IDX_W-1:0]          reg_idx;
  logic                          wr;
  logic                          trig_busy;
  logic signed [TRIG_WIDTH-1:0]  sine;
  logic signed [TRIG_WIDTH:0]    cosine;
  logic                          q_valid;
  logic                          q_pop;
  logic [COORD_WIDTH-1:0]        q_x;
  logic [COORD_WIDTH-1:0]        q_y;
  logic [COORD_WIDTH-1:0]        out_x;
  logic [COORD_WIDTH-1:0]        out_y;
  logic                          out_sat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:REG_SHIFT];
  assign wr      = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_turns <= '0;
      offset_x    <= '0;
      offset_y    <= '0;
    end else if (wr) begin
      case (reg_idx)
        REG_ANGLE:    angle_turns <= pwdata[ANGLE_W-1:0];
        REG_OFFSET_X: offset_x    <= pwdata[COORD_WIDTH-1:0];
        REG_OFFSET_Y: offset_y    <= pwdata[COORD_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      REG_ANGLE:    prdata = APB_W'(angle_turns);
      REG_OFFSET_X: prdata = APB_W'($signed(offset_x));
      REG_OFFSET_Y: prdata = APB_W'($signed(offset_y));
      default:      prdata = '0;
    endcase
  end

  rtp_trig #(
    .TRIG_WIDTH (TRIG_WIDTH)
  ) u_trig (
    .clk    (clk),
    .rst    (rst),
    .start  (wr && (reg_idx == REG_ANGLE)),
    .angle  (pwdata[ANGLE_W-1:0]),
    .busy   (trig_busy),
    .sine   (sine),
    .cosine (cosine)
  );

  rtp_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .hold     (trig_busy),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .in_x     (s_tdata[COORD_WIDTH-1:0]),
    .in_y     (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_x      (q_x),
    .q_y      (q_y)
  );

  rtp_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .TRIG_WIDTH  (TRIG_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_x      (q_x),
    .q_y      (q_y),
    .sine     (sine),
    .cosine   (cosine),
    .offset_x (offset_x),
    .offset_y (offset_y),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_sat  (out_sat)
  );

  assign m_tdata = IN_TW'({out_y, out_x});
  assign m_tuser = out_sat;

endmodule

>>> rtl/rtp_trig.sv
// Sine/cosine sequencer: evaluates the Taylor series once per angle write
// on one shared multiplier, dividing by reciprocal multiplication. Uses rtp_pkg.
module rtp_trig #(
  parameter int TRIG_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [rtp_pkg::ANGLE_W-1:0]       angle,
  output logic                              busy,
  output logic signed [TRIG_WIDTH-1:0]      sine,
  output logic signed [TRIG_WIDTH:0]        cosine
);
  import rtp_pkg::*;

  localparam int F   = TRIG_WIDTH - 1;
  localparam int TCW = TRIG_WIDTH + 1;
  localparam logic [31:0] RND_HALF = 32'(1) << (29 - F);
  localparam logic signed [TCW-1:0] COS_ONE = TCW'(1) << F;
  localparam logic signed [TCW-1:0] SIN_MAX = COS_ONE - TCW'(1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_X    = 7'b0000010,
    ST_X2   = 7'b0000100,
    ST_M    = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_S    = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_t;

  state_t                 state;
  quad_t                  quad;
  logic                   big_r;
  logic [RES_W-1:0]       t;
  logic [Q30_W-1:0]       x;
  logic [Q30_W-1:0]       x2;
  logic [Q30_W-1:0]       s_acc;
  logic [30:0]            h;
  logic [Q30_W-1:0]       dvd;
  logic [DIV_IDX_W-1:0]   didx;

  logic [31:0]            mul_a;
  logic [31:0]            mul_b;
  logic [63:0]            mul_p;
  logic [Q30_W-1:0]       quot_next;
  logic [RES_W:0]         res;
  logic [RES_W:0]         res_mirror;
  logic [31:0]            rnd_s;
  logic [31:0]            rnd_c;
  logic [F:0]             s_round;
  logic [F:0]             c_round;
  logic signed [TCW-1:0]  sp;
  logic signed [TCW-1:0]  cp;
  logic signed [TCW-1:0]  a_val;
  logic signed [TCW-1:0]  b_val;

  assign busy = (state != ST_IDLE);

  // Pick multiplier operands for the current step
  always_comb begin
    case (state)
      ST_X: begin
        mul_a = 32'(t);
        mul_b = PI_SCALE;
      end
      ST_X2: begin
        mul_a = 32'(x);
        mul_b = 32'(x);
      end
      ST_M: begin
        mul_a = 32'(x2);
        mul_b = 32'(h);
      end
      ST_DIV: begin
        mul_a = 32'(dvd);
        mul_b = SERIES_RECIP[didx];
      end
      ST_S: begin
        mul_a = 32'(x);
        mul_b = 32'(h);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = 64'(mul_a) * 64'(mul_b);
  end

  // Quotient by the current divisor from the reciprocal product
  assign quot_next = Q30_W'(mul_p >> SERIES_SHIFT[didx]);

  // Fold the angle into the first eighth of a turn
  assign res        = {1'b0, angle[RES_W-1:0]};
  assign res_mirror = RES_QUARTER - res;

  // Round both series to F fraction bits, then map onto the quadrant
  always_comb begin
    rnd_s   = 32'(s_acc) + RND_HALF;
    rnd_c   = 32'(h) + RND_HALF;
    s_round = rnd_s[30:30-F];
    c_round = rnd_c[30:30-F];
    sp      = big_r ? $signed({1'b0, c_round}) : $signed({1'b0, s_round});
    cp      = big_r ? $signed({1'b0, s_round}) : $signed({1'b0, c_round});
    case (quad)
      QUAD_0: begin
        a_val = sp;
        b_val = cp;
      end
      QUAD_1: begin
        a_val = cp;
        b_val = -sp;
      end
      QUAD_2: begin
        a_val = -sp;
        b_val = -cp;
      end
      default: begin
        a_val = -cp;
        b_val = sp;
      end
    endcase
    // Sine of a quarter turn does not fit; clamp it
    if (a_val > SIN_MAX) begin
      a_val = SIN_MAX;
    end
  end

  // Sequencer; a new angle restarts it from any state
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      sine   <= '0;
      cosine <= COS_ONE;
    end else if (start) begin
      state <= ST_X;
      quad  <= quad_t'(angle[ANGLE_W-1:QUAD_LSB]);
      big_r <= (res > RES_EIGHTH);
      t     <= (res > RES_EIGHTH) ? res_mirror[RES_W-1:0] : res[RES_W-1:0];
      h     <= Q30_ONE;
      didx  <= '0;
    end else begin
      case (state)
        ST_X: begin
          x     <= mul_p[44:15];
          state <= ST_X2;
        end
        ST_X2: begin
          x2    <= mul_p[59:30];
          state <= ST_M;
        end
        ST_M: begin
          dvd   <= mul_p[59:30];
          state <= ST_DIV;
        end
        ST_DIV: begin
          h <= Q30_ONE - {1'b0, quot_next};
          if (didx == SINE_LAST) begin
            state <= ST_S;
          end else if (didx == COS_LAST) begin
            state <= ST_FIN;
          end else begin
            didx  <= didx + DIV_IDX_W'(1);
            state <= ST_M;
          end
        end
        ST_S: begin
          s_acc <= mul_p[59:30];
          h     <= Q30_ONE;
          didx  <= COS_FIRST;
          state <= ST_M;
        end
        ST_FIN: begin
          sine   <= a_val[TRIG_WIDTH-1:0];
          cosine <= b_val;
          state  <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> busy) else $error("trig unit did not start");
  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (cosine <= COS_ONE && cosine >= -COS_ONE))
    else $error("cached cosine out of range");
  a_div_index: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (didx <= COS_LAST)) else $error("divisor index overrun");

endmodule

>>> rtl/rtp_front.sv
// Front part: accepts points and queues them for the datapath; holds off
// new points while the trig unit updates. Uses rtp_pkg.
module rtp_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   hold,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [COORD_WIDTH-1:0] in_x,
  input  logic [COORD_WIDTH-1:0] in_y,
  output logic                   q_valid,
  input  logic                   q_pop,
  output logic [COORD_WIDTH-1:0] q_x,
  output logic [COORD_WIDTH-1:0] q_y
);
  import rtp_pkg::*;

  logic [COORD_WIDTH-1:0] qx [QUEUE_DEPTH];
  logic [COORD_WIDTH-1:0] qy [QUEUE_DEPTH];
  logic [QPTR_W-1:0]      wptr;
  logic [QPTR_W-1:0]      rptr;
  logic [QCNT_W-1:0]      count;
  logic                   push;

  assign s_tready = !hold && (count != QCNT_W'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != '0);
  assign q_x      = qx[rptr];
  assign q_y      = qy[rptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      case ({push, q_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Store the accepted item
  always_ff @(posedge clk) begin
    if (push) begin
      qx[wptr] <= in_x;
      qy[wptr] <= in_y;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH)) else $error("queue overfilled");
  a_hold_blocks: assert property (@(posedge clk) disable iff (rst)
    hold |-> !s_tready) else $error("item taken during trig update");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid) else $error("pop from empty queue");

endmodule

>>> rtl/rtp_back.sv
// Back part: four-stage multiply/add pipeline with rounding, saturation
// and an output register. Uses cached trig and offsets from the top level.
module rtp_back #(
  parameter int COORD_WIDTH = 32,
  parameter int TRIG_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic [COORD_WIDTH-1:0]        q_x,
  input  logic [COORD_WIDTH-1:0]        q_y,
  input  logic signed [TRIG_WIDTH-1:0]  sine,
  input  logic signed [TRIG_WIDTH:0]    cosine,
  input  logic [COORD_WIDTH-1:0]        offset_x,
  input  logic [COORD_WIDTH-1:0]        offset_y,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [COORD_WIDTH-1:0]        out_x,
  output logic [COORD_WIDTH-1:0]        out_y,
  output logic                          out_sat
);
  localparam int F     = TRIG_WIDTH - 1;
  localparam int TCW   = TRIG_WIDTH + 1;
  localparam int LO_W  = COORD_WIDTH / 2;
  localparam int HI_W  = COORD_WIDTH - LO_W;
  localparam int LOP_W = LO_W + 1 + TCW;
  localparam int HIP_W = HI_W + TCW;
  localparam int PW    = COORD_WIDTH + TCW;
  localparam int DW    = PW + 1;
  localparam int SW    = PW + 2;
  localparam int RW    = SW - F;
  localparam logic [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic                    adv;
  logic                    va, vb, vc, vd;
  logic [COORD_WIDTH-1:0]  op_c [4];
  logic signed [TCW-1:0]   op_t [4];
  logic signed [TCW-1:0]   sin_e;
  logic signed [LOP_W-1:0] lo_p [4];
  logic signed [HIP_W-1:0] hi_p [4];
  logic signed [LOP_W-1:0] a_lo [4];
  logic signed [HIP_W-1:0] a_hi [4];
  logic signed [PW-1:0]    b_p [4];
  logic signed [DW-1:0]    c_x, c_y;
  logic signed [SW-1:0]    d_x, d_y;
  logic signed [SW-1:0]    ox_term, oy_term;
  logic signed [RW-1:0]    sh_x, sh_y;
  logic                    fit_x, fit_y;

  // The whole pipeline moves when the output register can take a result
  assign adv   = !m_tvalid || m_tready;
  assign q_pop = adv && q_valid;
  assign sin_e = TCW'(sine);

  // Stage A operands: x*cos, y*sin, x*sin, y*cos, each split into halves
  always_comb begin
    op_c[0] = q_x; op_t[0] = cosine;
    op_c[1] = q_y; op_t[1] = sin_e;
    op_c[2] = q_x; op_t[2] = sin_e;
    op_c[3] = q_y; op_t[3] = cosine;
    for (int i = 0; i < 4; i++) begin
      lo_p[i] = $signed({1'b0, op_c[i][LO_W-1:0]}) * op_t[i];
      hi_p[i] = $signed(op_c[i][COORD_WIDTH-1:LO_W]) * op_t[i];
    end
  end

  // Offset in Q(COORD_WIDTH).(F) with the rounding half already in place
  assign ox_term = SW'($signed({offset_x, 1'b1, {(F-1){1'b0}}}));
  assign oy_term = SW'($signed({offset_y, 1'b1, {(F-1){1'b0}}}));

  // Drop the fraction and check the range
  assign sh_x  = RW'(d_x >>> F);
  assign sh_y  = RW'(d_y >>> F);
  assign fit_x = (&sh_x[RW-1:COORD_WIDTH-1]) || !(|sh_x[RW-1:COORD_WIDTH-1]);
  assign fit_y = (&sh_y[RW-1:COORD_WIDTH-1]) || !(|sh_y[RW-1:COORD_WIDTH-1]);

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      va       <= 1'b0;
      vb       <= 1'b0;
      vc       <= 1'b0;
      vd       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      va       <= q_valid;
      vb       <= va;
      vc       <= vb;
      vd       <= vc;
      m_tvalid <= vd;
    end
  end

  // Stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      a_lo <= lo_p;
      a_hi <= hi_p;
      for (int i = 0; i < 4; i++) begin
        b_p[i] <= (PW'(a_hi[i]) <<< LO_W) + PW'(a_lo[i]);
      end
      c_x     <= DW'(b_p[0]) - DW'(b_p[1]);
      c_y     <= DW'(b_p[2]) + DW'(b_p[3]);
      d_x     <= SW'(c_x) + ox_term;
      d_y     <= SW'(c_y) + oy_term;
      out_x   <= fit_x ? sh_x[COORD_WIDTH-1:0] : (sh_x[RW-1] ? C_MIN : C_MAX);
      out_y   <= fit_y ? sh_y[COORD_WIDTH-1:0] : (sh_y[RW-1] ? C_MIN : C_MAX);
      out_sat <= !fit_x || !fit_y;
    end
  end

  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_sat) |->
      (out_x == C_MAX || out_x == C_MIN || out_y == C_MAX || out_y == C_MIN))
    else $error("saturation flag without clamped value");
  a_last_stage_out: assert property (@(posedge clk) disable iff (rst)
    (adv && vd) |=> m_tvalid) else $error("result lost at output register");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (vd && !adv) |=> vd) else $error("last stage dropped during stall");

endmodule

>>> bench/tb_rotate_translate_point_2d.sv
// Self-checking bench for rotate_translate_point_2d: points in over the input stream,
// rotated and shifted results out, angle and offsets set over the APB port.
// Depends on rtp_pkg and the RTL top level only.
module tb_rotate_translate_point_2d;
  timeunit 1ns;
  timeprecision 1ps;

  import rtp_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int TRIG_FRAC = 15;
  localparam int SINE_MAX = (1 << TRIG_FRAC) - 1;
  localparam logic [63:0] ROUND_HALF = 64'd1 << (TRIG_FRAC - 1);
  localparam logic signed [31:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  // Register index that decodes to nothing
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic sat;
  } point_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        s_tvalid, s_tready;
  logic [63:0] s_tdata;      // in_x [31:0], in_y [63:32]
  logic        m_tvalid, m_tready;
  logic [63:0] m_tdata;      // out_x [31:0], out_y [63:32]
  logic [0:0]  m_tuser;      // saturated

  // Predictor copy of the configuration and cached trig values
  logic [15:0]        angle_reg;
  logic signed [31:0] offset_x_reg, offset_y_reg;
  int                 sine_q, cosine_q;

  point_result_t expected_points[$];
  int errors, points_sent, results_seen, saturated_seen, reg_writes;
  int send_idle_pct, recv_stall_pct, holdoff_cycles;
  int unsigned cycle_count;

  rotate_translate_point_2d dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_points.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Taylor series for sine and cosine of t/32768*pi, both rounded to Q1.15
  function automatic void eval_series(input logic [63:0] t, output logic [63:0] sn,
                                      output logic [63:0] cs);
    logic [63:0] x, x2, h;
    int k;
    x  = (t * 64'(PI_SCALE)) >> 15;
    x2 = (x * x) >> Q30_W;
    h  = 64'(Q30_ONE);
    for (k = 0; k <= SINE_LAST; k++)
      h = 64'(Q30_ONE) - ((x2 * h) >> Q30_W) / 64'(SERIES_DIV[k]);
    sn = (((x * h) >> Q30_W) + ROUND_HALF) >> (Q30_W - TRIG_FRAC);
    h  = 64'(Q30_ONE);
    for (k = COS_FIRST; k <= COS_LAST; k++)
      h = 64'(Q30_ONE) - ((x2 * h) >> Q30_W) / 64'(SERIES_DIV[k]);
    cs = (h + ROUND_HALF) >> (Q30_W - TRIG_FRAC);
  endfunction

  // Recompute the cached sine and cosine from the angle register
  function automatic void refresh_trig();
    logic [63:0] s_raw, c_raw;
    logic [RES_W-1:0] res;
    logic [1:0] quad;
    int sn, cs, a, b;
    quad = angle_reg[ANGLE_W-1:QUAD_LSB];
    res  = angle_reg[RES_W-1:0];
    // Above one eighth of a turn, fold onto the complementary angle
    if (res <= RES_EIGHTH) eval_series(64'(res), s_raw, c_raw);
    else eval_series(64'(RES_QUARTER - res), c_raw, s_raw);
    sn = int'(s_raw);
    cs = int'(c_raw);
    case (quad)
      2'd0: begin a = sn; b = cs; end
      2'd1: begin a = cs; b = -sn; end
      2'd2: begin a = -sn; b = -cs; end
      default: begin a = -cs; b = sn; end
    endcase
    // Sine has no room for +1.0
    if (a > SINE_MAX) a = SINE_MAX;
    sine_q   = a;
    cosine_q = b;
  endfunction

  function automatic logic signed [31:0] clamp_coord(input longint v, inout logic sat);
    if (v > longint'(COORD_MAX)) begin
      sat = 1'b1;
      return COORD_MAX;
    end
    if (v < longint'(COORD_MIN)) begin
      sat = 1'b1;
      return COORD_MIN;
    end
    return v[31:0];
  endfunction

  // Rotate, shift, round half up and saturate one point
  function automatic point_result_t transform_point(input logic signed [31:0] px,
                                                    input logic signed [31:0] py);
    point_result_t r;
    longint ax, ay;
    logic sat;
    sat = 1'b0;
    ax = longint'(px) * cosine_q - longint'(py) * sine_q
         + (longint'(offset_x_reg) <<< TRIG_FRAC) + longint'(ROUND_HALF);
    ay = longint'(px) * sine_q + longint'(py) * cosine_q
         + (longint'(offset_y_reg) <<< TRIG_FRAC) + longint'(ROUND_HALF);
    r.x = clamp_coord(ax >>> TRIG_FRAC, sat);
    r.y = clamp_coord(ay >>> TRIG_FRAC, sat);
    r.sat = sat;
    return r;
  endfunction

  // Mix of full-range, moderate, small and extreme coordinates
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $signed($urandom_range(32'h0FFF_FFFF)) - 32'sh0800_0000;
      2: return $signed($urandom_range(32'h001F_FFFF)) - 32'sh0010_0000;
      3: begin
        case ($urandom_range(3))
          0: return COORD_MAX;
          1: return COORD_MIN;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
      default: return $signed($urandom_range(32'h01FF_FFFF)) - 32'sh0100_0000;
    endcase
  endfunction

  // Offer one point after a random gap; record its expected result at acceptance
  task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom, $urandom};
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {py, px};
    do @(posedge clk); while (!s_tready);
    expected_points.push_back(transform_point(px, py));
    points_sent++;
    @(negedge clk);
  endtask

  // Drop valid, let every expected result drain, then give the pipeline some slack
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_points.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ANGLE: begin
        angle_reg = data[15:0];
        refresh_trig();
      end
      REG_OFFSET_X: offset_x_reg = data;
      REG_OFFSET_Y: offset_y_reg = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic reg_check(input logic [REG_IDX_W-1:0] idx, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      $display("%0t: register %0d read expected %h actual %h", $time, idx, want, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic check_registers();
    reg_check(REG_ANGLE, {16'h0, angle_reg});
    reg_check(REG_OFFSET_X, offset_x_reg);
    reg_check(REG_OFFSET_Y, offset_y_reg);
  endtask

  task automatic configure(input logic [15:0] angle, input logic signed [31:0] ox,
                           input logic signed [31:0] oy);
    wait_idle();
    reg_write(REG_ANGLE, {16'h0, angle});
    reg_write(REG_OFFSET_X, ox);
    reg_write(REG_OFFSET_Y, oy);
    check_registers();
  endtask

  // Drive the result ready line: long hold-off when asked, else random stalls
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_cycles > 0) begin
        m_tready <= 1'b0;
        holdoff_cycles--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    point_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser[0]) saturated_seen++;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result expected none actual x=%h y=%h sat=%b",
                 $time, m_tdata[31:0], m_tdata[63:32], m_tuser[0]);
        errors++;
      end else begin
        want = expected_points.pop_front();
        if (m_tdata[31:0] !== want.x) begin
          $display("%0t: out_x expected %h actual %h", $time, want.x, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[63:32] !== want.y) begin
          $display("%0t: out_y expected %h actual %h", $time, want.y, m_tdata[63:32]);
          errors++;
        end
        if (m_tuser[0] !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want.sat, m_tuser[0]);
          errors++;
        end
      end
    end
  end

  // Reset state: cosine one, sine zero, no offset
  task automatic test_identity_extremes();
    send_point(COORD_MAX, COORD_MIN);
    send_point(COORD_MIN, COORD_MAX);
    send_point(32'sd0, -32'sd1);
    send_point(32'sd1, 32'sd0);
  endtask

  // Offsets at their bounds push results past the range
  task automatic test_offset_saturation();
    configure(16'h0000, COORD_MAX, COORD_MIN);
    send_point(COORD_MAX, COORD_MIN);
    send_point(COORD_MIN, COORD_MAX);
    send_point(32'sd1, -32'sd1);
  endtask

  // Quarter turn (sine clamp), eighth turn and just past it, half, three quarters, just under a full turn
  task automatic test_special_angles();
    logic [15:0] angles [6];
    angles = '{16'h4000, 16'h2000, 16'h2001, 16'h8000, 16'hC000, 16'hFFFF};
    foreach (angles[i]) begin
      configure(angles[i], 32'sd0, 32'sd0);
      send_point(COORD_MAX, COORD_MIN);
      send_point(COORD_MIN, COORD_MAX);
    end
  endtask

  // A write to an undecoded address must leave every register alone
  task automatic test_unknown_register();
    configure(16'h1234, 32'sh0001_8000, -32'sh0002_4000);
    reg_write(REG_UNUSED, $urandom);
    check_registers();
    send_point(32'sh0003_0000, -32'sh0001_0000);
    send_point(rand_coord(), rand_coord());
  endtask

  // Two random settings per idle mix, random points under each
  task automatic test_random_traffic(input int idle_pct, input int stall_pct);
    logic [15:0] angle;
    int k, n;
    for (k = 0; k < 2; k++) begin
      case ($urandom_range(4))
        0: angle = 16'h0000;
        1: angle = 16'hFFFF;
        2: angle = {2'($urandom_range(3)), 14'h0};
        default: angle = 16'($urandom);
      endcase
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      configure(angle, rand_coord(), rand_coord());
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (n = 0; n < 62; n++) send_point(rand_coord(), rand_coord());
    end
  endtask

  // Hold results off long enough for the block to fill and stall its input
  task automatic test_output_backpressure();
    int n;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    configure(16'($urandom), rand_coord(), rand_coord());
    @(posedge clk);
    holdoff_cycles = 150;
    @(negedge clk);
    for (n = 0; n < 40; n++) send_point(rand_coord(), rand_coord());
    wait_idle();
  endtask

  initial begin
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    errors = 0;
    points_sent = 0;
    results_seen = 0;
    saturated_seen = 0;
    reg_writes = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    holdoff_cycles = 0;
    cycle_count = 0;
    angle_reg = '0;
    offset_x_reg = '0;
    offset_y_reg = '0;
    sine_q = 0;
    cosine_q = 1 << TRIG_FRAC;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_identity_extremes();
    test_offset_saturation();
    test_special_angles();
    test_unknown_register();
    test_random_traffic(0, 0);
    test_random_traffic(76, 0);
    test_random_traffic(0, 76);
    test_random_traffic(17, 17);
    test_output_backpressure();
    wait_idle();

    $display("Sent %0d points through %0d register writes; %0d results, %0d saturated.",
             points_sent, reg_writes, results_seen, saturated_seen);
    $display("Covered special angles, offset bounds, four idle mixes and a long output stall.");
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rtp_pkg.sv
rtl/rtp_trig.sv
rtl/rtp_front.sv
rtl/rtp_back.sv
rtl/rotate_translate_point_2d.sv
bench/tb_rotate_translate_point_2d.sv
